// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, operation and error codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int DEF_WIDTH = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ZDIV = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic combine;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } rau_cmd_t;

  typedef struct packed {
    logic early;
    logic gcd_done;
    logic div_done;
  } rau_sts_t;

endpackage

// ===== design/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: products, gcd loop, division by the gcd, result strobe
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  rau_sts_t sts,
  output rau_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MULA = 8'b0000_0010,
    S_MULB = 8'b0000_0100,
    S_COMB = 8'b0000_1000,
    S_GCD  = 8'b0001_0000,
    S_DINI = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_nxt   = S_GCD;
      end
      S_GCD: begin
        if (sts.early) begin
          state_nxt = S_DONE;
        end else if (sts.gcd_done) begin
          state_nxt = S_DINI;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DINI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== design/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// datapath: cross products, binary gcd, bit-serial division by the gcd
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                clk,
  input  rau_cmd_t            cmd,
  output rau_sts_t            sts,
  input  logic [2:0]          in_operation,
  input  logic signed [31:0]  in_a_num,
  input  logic [30:0]         in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic [30:0]         in_b_den,
  output logic signed [31:0]  out_res_num,
  output logic [30:0]         out_res_den,
  output logic                out_a_less,
  output logic                out_a_equal,
  output logic                out_a_greater,
  output logic [1:0]          out_error_code
);

  localparam int PW = 2 * WIDTH + 1;
  localparam int CW = $clog2(PW + 1);
  localparam int SW = $clog2(PW + 1);

  logic [2:0]                 op_r;
  logic signed [WIDTH-1:0]    an_r, bn_r;
  logic [WIDTH-2:0]           ad_r, bd_r;
  logic signed [2*WIDTH-1:0]  lhs_r, rhs_r, p3_r, p4_r;
  logic [PW-1:0]              nm_r, dm_r, u_r, v_r;
  logic                       neg_r, early_r;
  logic [1:0]                 err_r;
  logic [SW-1:0]              sh_r;
  logic [PW-1:0]              g_r;
  logic [PW-1:0]              qn_r, qd_r, rn_r, rd_r;
  logic [CW-1:0]              cnt_r;
  logic                       lt_r, eq_r, gt_r;

  logic signed [WIDTH-1:0]    ma1, ma2;
  logic signed [WIDTH:0]      mb1, mb2;
  logic signed [PW:0]         n_c, d_c;
  logic [PW-1:0]              nmag, dmag, u_nxt, v_nxt;
  logic [PW:0]                rn_sh, rd_sh;
  logic [PW:0]                gext;
  logic [PW-1:0]              lim;

  assign lim = {{(PW-WIDTH){1'b0}}, 1'b1, {(WIDTH-1){1'b0}}};

  // products are formed two at a time on two multipliers
  always_comb begin
    ma1 = an_r;
    mb1 = {2'b00, bd_r};
    ma2 = bn_r;
    mb2 = {2'b00, ad_r};
    if (cmd.mul_b) begin
      unique case (op_r)
        OP_MUL: begin
          mb1 = {bn_r[WIDTH-1], bn_r};
          ma2 = $signed({1'b0, ad_r});
          mb2 = {2'b00, bd_r};
        end
        OP_DIV: begin
          mb1 = {2'b00, bd_r};
          ma2 = $signed({1'b0, ad_r});
          mb2 = {bn_r[WIDTH-1], bn_r};
        end
        default: begin
          ma1 = $signed({1'b0, ad_r});
          mb1 = {2'b00, bd_r};
          ma2 = '0;
          mb2 = '0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (op_r)
      OP_ADD:  n_c = (PW+1)'(lhs_r) + (PW+1)'(rhs_r);
      OP_SUB:  n_c = (PW+1)'(lhs_r) - (PW+1)'(rhs_r);
      OP_NEG:  n_c = -(PW+1)'(an_r);
      default: n_c = (PW+1)'(p3_r);
    endcase
    if (op_r == OP_NEG) begin
      d_c = (PW+1)'($signed({1'b0, ad_r}));
    end else if (op_r == OP_MUL || op_r == OP_DIV) begin
      d_c = (PW+1)'(p4_r);
    end else begin
      d_c = (PW+1)'(p3_r);
    end
    nmag = n_c[PW] ? PW'(-n_c) : PW'(n_c);
    dmag = d_c[PW] ? PW'(-d_c) : PW'(d_c);
  end

  // one binary gcd step
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  assign gext  = {1'b0, g_r};
  assign rn_sh = {rn_r, qn_r[PW-1]};
  assign rd_sh = {rd_r, qd_r[PW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      an_r <= in_a_num[WIDTH-1:0];
      bn_r <= in_b_num[WIDTH-1:0];
      ad_r <= in_a_den[WIDTH-2:0];
      bd_r <= in_b_den[WIDTH-2:0];
    end
    if (cmd.mul_a) begin
      lhs_r <= (2*WIDTH)'(ma1) * (2*WIDTH)'(mb1);
      rhs_r <= (2*WIDTH)'(ma2) * (2*WIDTH)'(mb2);
    end
    if (cmd.mul_b) begin
      p3_r <= (2*WIDTH)'(ma1) * (2*WIDTH)'(mb1);
      p4_r <= (2*WIDTH)'(ma2) * (2*WIDTH)'(mb2);
    end
    if (cmd.combine) begin
      lt_r    <= lhs_r < rhs_r;
      eq_r    <= lhs_r == rhs_r;
      gt_r    <= lhs_r > rhs_r;
      neg_r   <= n_c[PW] ^ d_c[PW];
      nm_r    <= nmag;
      dm_r    <= dmag;
      u_r     <= nmag;
      v_r     <= dmag;
      sh_r    <= '0;
      err_r   <= ERR_NONE;
      early_r <= 1'b0;
      if (op_r > OP_NEG) begin
        early_r <= 1'b1;
      end else if (ad_r == '0 || (op_r != OP_NEG && bd_r == '0) ||
                   (op_r == OP_DIV && bn_r == '0)) begin
        early_r <= 1'b1;
        err_r   <= ERR_ZDIV;
      end
    end
    if (cmd.gcd_step) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      if (!u_r[0] && !v_r[0]) begin
        sh_r <= sh_r + 1'b1;
      end
    end
    if (cmd.div_init) begin
      // gcd(0, d) is d; zero numerator leaves v as the result
      g_r   <= (u_r == '0 ? v_r : u_r) << sh_r;
      qn_r  <= nm_r;
      qd_r  <= dm_r;
      rn_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (rn_sh >= gext) begin
        rn_r <= PW'(rn_sh - gext);
        qn_r <= {qn_r[PW-2:0], 1'b1};
      end else begin
        rn_r <= PW'(rn_sh);
        qn_r <= {qn_r[PW-2:0], 1'b0};
      end
      if (rd_sh >= gext) begin
        rd_r <= PW'(rd_sh - gext);
        qd_r <= {qd_r[PW-2:0], 1'b1};
      end else begin
        rd_r <= PW'(rd_sh);
        qd_r <= {qd_r[PW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      out_a_less    <= lt_r;
      out_a_equal   <= eq_r;
      out_a_greater <= gt_r;
      out_res_num   <= '0;
      out_res_den   <= '0;
      out_error_code <= err_r;
      if (!early_r) begin
        if (qd_r > lim - 1'b1 ||
            ((neg_r && qn_r != '0) ? qn_r > lim : qn_r > lim - 1'b1)) begin
          out_error_code <= ERR_OVF;
        end else begin
          out_error_code <= ERR_NONE;
          out_res_num <= 32'($signed((neg_r && qn_r != '0) ?
                          WIDTH'(-qn_r) : WIDTH'(qn_r)));
          out_res_den <= 31'(qd_r[WIDTH-2:0]);
        end
      end
    end
  end

  assign sts.early    = early_r;
  assign sts.gcd_done = (u_r == '0) || (v_r == '0) || (u_r == v_r);
  assign sts.div_done = (cnt_r == CW'(PW - 1));

endmodule

// ===== design/rational_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// exact rational add, subtract, multiply, divide and negate with normalizing
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; operands and the
// operation are captured at that edge and busy stays high until the result
// strobe. out_valid is high for one cycle with the normalized fraction, the
// comparison flags and the error code; the receiver cannot stall it.
// a request steps through the product and setup states (MULA, MULB, COMB),
// then the binary gcd loop at one gcd step per cycle until the gcd is found,
// a setup state for the divider, bit-serial division of the magnitudes
// (2*WIDTH+1 bits wide) by the gcd, one quotient bit per step, and a finish
// state from which the result and the strobe are registered. the length of
// the gcd loop depends on the operands. zero-divisor and unused-operation
// requests skip the loop and the division. requests are handled one at a time;
// the next one can be taken in the strobe cycle. synchronous reset returns
// the controller to idle and drops out_valid; no request in flight survives.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_a_num,
  input  logic [30:0]        in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic [30:0]        in_b_den,
  output logic               out_valid,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_a_less,
  output logic               out_a_equal,
  output logic               out_a_greater,
  output logic [1:0]         out_error_code
);

  rau_cmd_t cmd;
  rau_sts_t sts;
  logic     valid_r;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_operation),
    .in_a_num       (in_a_num),
    .in_a_den       (in_a_den),
    .in_b_num       (in_b_num),
    .in_b_den       (in_b_den),
    .out_res_num    (out_res_num),
    .out_res_den    (out_res_den),
    .out_a_less     (out_a_less),
    .out_a_equal    (out_a_equal),
    .out_a_greater  (out_a_greater),
    .out_error_code (out_error_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  assign out_valid = valid_r;

endmodule

// ===== design/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// port-level checks on the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_checker
  import rau_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [30:0] out_res_den,
  input logic        out_a_less,
  input logic        out_a_equal,
  input logic        out_a_greater,
  input logic [1:0]  out_error_code
);

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("flags not one-hot");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request not taken");

  a_valid_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("strobe outside request");

  a_den_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |-> out_res_den == '0)
    else $error("nonzero denominator with error");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_res_den    (out_res_den),
  .out_a_less     (out_a_less),
  .out_a_equal    (out_a_equal),
  .out_a_greater  (out_a_greater),
  .out_error_code (out_error_code)
);
